### hw/rtl/sorted_table_linear_interpolator_core_macros.svh
// Assertion macros for the sorted table interpolator.
// Uses the clk and arst_n names of the module that includes it.
`ifndef SORTED_TABLE_LINEAR_INTERPOLATOR_CORE_MACROS_SVH
`define SORTED_TABLE_LINEAR_INTERPOLATOR_CORE_MACROS_SVH

`define STLI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define STLI_ASSERT_ALWAYS(lbl, cond, msg) \
	`STLI_ASSERT_IMP(lbl, 1'b1, cond, msg)

`endif

### hw/rtl/stli_pkg.sv
// Constants and types of the sorted table interpolator.
// No dependencies.
package stli_pkg;
	localparam int DEPTH = 1024;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = 31;
	localparam int VW = 48;
	localparam int DVW = VW + 1;
	localparam int PRODW = PW + DVW;
	localparam int QW = 51;
	localparam int STEPW = 7;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_QUERY = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_EXACT    = 3'd0,
		ST_INTERP   = 3'd1,
		ST_EXTRAP   = 3'd2,
		ST_RANGE    = 3'd3,
		ST_UNUSABLE = 3'd4,
		ST_LOADED   = 3'd5,
		ST_SKIPPED  = 3'd6,
		ST_FULL     = 3'd7
	} status_t;
endpackage

### hw/rtl/stli_if.sv
// Word channel interfaces of the sorted table interpolator.
// Depends on stli_pkg.
interface stli_req_if import stli_pkg::*; ();
	logic          valid;
	logic          ready;
	logic [1:0]    action;
	logic [PW-1:0] position;
	logic [VW-1:0] map_value;
	modport source(output valid, action, position, map_value, input ready);
	modport sink(input valid, action, position, map_value, output ready);
endinterface

interface stli_rsp_if import stli_pkg::*; ();
	logic          valid;
	logic          ready;
	logic [VW-1:0] value;
	logic [2:0]    status;
	modport source(output valid, value, status, input ready);
	modport sink(input valid, value, status, output ready);
endinterface

### hw/rtl/stli_ram.sv
// Generic simple dual port RAM with registered read.
// No dependencies.
module stli_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### hw/rtl/sorted_table_linear_interpolator_core.sv
// Top level of the sorted breakpoint table with linear interpolation.
// Depends on stli_pkg, stli_if, stli_ram and the assertion macro header.
//
// Channel  Dir  Payload                     Handshake
// req      in   action, position, map_value valid/ready
// rsp      out  value, status               valid/ready
//
// A load runs a binary search, shifts entries up to open its slot and then
// writes the new entry. A query runs the binary search, reads the two
// neighbors, then does a shift-and-add multiply and a restoring divide.
// Every read of the two RAMs uses one shared read address.
// Reset empties the table and sets strict mode; no clearing pass is needed.
// A result waiting on rsp holds the next word until the output is free.
`include "sorted_table_linear_interpolator_core_macros.svh"

module sorted_table_linear_interpolator_core import stli_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	stli_req_if.sink   req,
	stli_rsp_if.source rsp
);
	typedef enum logic [15:0] {
		S_IDLE   = 16'h0001,
		S_SRCH   = 16'h0002,
		S_SCMP   = 16'h0004,
		S_LDCHK  = 16'h0008,
		S_SH     = 16'h0010,
		S_SHWR   = 16'h0020,
		S_QCHK   = 16'h0040,
		S_QRD0   = 16'h0080,
		S_QRD1   = 16'h0100,
		S_QCAP   = 16'h0200,
		S_MUL    = 16'h0400,
		S_DIV    = 16'h0800,
		S_FIN    = 16'h1000,
		S_EMIT   = 16'h2000,
		S_SPARE0 = 16'h4000,
		S_SPARE1 = 16'h8000
	} state_t;

	localparam logic [QW:0] MAG_LIMIT = (QW+1)'(1) << (QW - 1);
	localparam logic signed [QW:0] RMAX = $signed({{(QW+1-VW+1){1'b0}}, {(VW-1){1'b1}}});
	localparam logic signed [QW:0] RMIN = $signed({{(QW+1-VW+1){1'b1}}, {(VW-1){1'b0}}});

	state_t state_q;
	logic strict_q, failed_q, has_prev_q;
	logic signed [VW-1:0] prev_q;
	logic [CW-1:0] count_q, lo_q, hi_q, mid_q, k_q;
	logic [AW-1:0] i0_q;
	action_t act_q;
	logic [PW-1:0] pos_q, p0_q, d_q;
	logic signed [VW-1:0] mv_q, v0_q;
	logic [PRODW-1:0] acc_q;
	logic [PW-1:0] a_q;
	logic [DVW-1:0] b_q;
	logic [PW-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic ovf_q, neg_q;
	logic [STEPW-1:0] cnt_q;
	logic [VW-1:0] res_value_q;
	status_t res_status_q;
	logic out_valid_q;
	logic [VW-1:0] out_value_q;
	logic [2:0] out_status_q;

	logic [AW-1:0] rd_addr, wr_addr;
	logic mem_we;
	logic [PW-1:0] wr_pos, rd_pos;
	logic [VW-1:0] wr_val, rd_val;
	logic [CW-1:0] mid;
	logic signed [PW:0] dq;
	logic signed [DVW-1:0] dv;
	logic [PW:0] div_t;
	logic div_ge;
	logic [QW:0] mag_raw, mag;
	logic signed [QW:0] v0_ext, r_sum, r_sat;
	logic round_up;

	stli_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_pos_ram (
		.clk(clk), .we(mem_we), .waddr(wr_addr), .wdata(wr_pos),
		.raddr(rd_addr), .rdata(rd_pos)
	);
	stli_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_val_ram (
		.clk(clk), .we(mem_we), .waddr(wr_addr), .wdata(wr_val),
		.raddr(rd_addr), .rdata(rd_val)
	);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.value = out_value_q;
	assign rsp.status = out_status_q;

	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign dq = $signed({1'b0, pos_q}) - $signed({1'b0, p0_q});
	assign dv = $signed({rd_val[VW-1], rd_val}) - $signed({v0_q[VW-1], v0_q});
	assign div_t = {rem_q, acc_q[PRODW-1]};
	assign div_ge = div_t >= {1'b0, d_q};
	assign round_up = {rem_q, 1'b0} >= {1'b0, d_q};
	assign mag_raw = {1'b0, quo_q} + (QW+1)'(round_up);
	assign mag = (ovf_q || mag_raw > MAG_LIMIT) ? MAG_LIMIT : mag_raw;
	assign v0_ext = (QW+1)'(v0_q);
	assign r_sum = neg_q ? v0_ext - $signed(mag) : v0_ext + $signed(mag);
	assign r_sat = (r_sum > RMAX) ? RMAX : ((r_sum < RMIN) ? RMIN : r_sum);

	always_comb begin
		rd_addr = '0;
		wr_addr = '0;
		mem_we = 1'b0;
		wr_pos = rd_pos;
		wr_val = rd_val;
		unique case (state_q)
			S_SRCH: begin
				rd_addr = (lo_q < hi_q) ? mid[AW-1:0] : lo_q[AW-1:0];
			end
			S_SH: begin
				if (k_q > lo_q) begin
					rd_addr = AW'(k_q - CW'(1));
				end else begin
					mem_we = 1'b1;
					wr_addr = lo_q[AW-1:0];
					wr_pos = pos_q;
					wr_val = mv_q;
				end
			end
			S_SHWR: begin
				mem_we = 1'b1;
				wr_addr = k_q[AW-1:0];
			end
			S_QRD0: rd_addr = i0_q;
			S_QRD1: rd_addr = i0_q + AW'(1);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			strict_q <= 1'b1;
			failed_q <= 1'b0;
			has_prev_q <= 1'b0;
			prev_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				strict_q <= cfg_wdata;
			end
			if (out_valid_q && rsp.ready && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						act_q <= action_t'(req.action);
						pos_q <= req.position;
						mv_q <= $signed(req.map_value);
						res_value_q <= '0;
						lo_q <= '0;
						hi_q <= count_q;
						state_q <= S_EMIT;
						unique case (action_t'(req.action))
							ACT_LOAD: begin
								if (failed_q) begin
									res_status_q <= ST_UNUSABLE;
								end else if (has_prev_q &&
									($signed(req.map_value) < prev_q ||
									($signed(req.map_value) == prev_q && strict_q))) begin
									failed_q <= 1'b1;
									res_status_q <= ST_UNUSABLE;
								end else begin
									prev_q <= $signed(req.map_value);
									has_prev_q <= 1'b1;
									if (has_prev_q && $signed(req.map_value) == prev_q) begin
										res_status_q <= ST_SKIPPED;
									end else begin
										state_q <= S_SRCH;
									end
								end
							end
							ACT_QUERY: begin
								if (failed_q || count_q < CW'(2)) begin
									res_status_q <= ST_UNUSABLE;
								end else begin
									state_q <= S_SRCH;
								end
							end
							ACT_CLEAR: begin
								count_q <= '0;
								prev_q <= '0;
								has_prev_q <= 1'b0;
								failed_q <= 1'b0;
								res_status_q <= ST_LOADED;
							end
							ACT_NONE: res_status_q <= ST_SKIPPED;
						endcase
					end
				end
				S_SRCH: begin
					if (lo_q < hi_q) begin
						mid_q <= mid;
						state_q <= S_SCMP;
					end else if (act_q == ACT_LOAD) begin
						if (lo_q < count_q) begin
							state_q <= S_LDCHK;
						end else if (count_q >= CW'(DEPTH)) begin
							res_status_q <= ST_FULL;
							state_q <= S_EMIT;
						end else begin
							k_q <= count_q;
							state_q <= S_SH;
						end
					end else if (lo_q < count_q) begin
						state_q <= S_QCHK;
					end else if (strict_q) begin
						res_status_q <= ST_RANGE;
						state_q <= S_EMIT;
					end else begin
						i0_q <= AW'(count_q - CW'(2));
						res_status_q <= ST_EXTRAP;
						state_q <= S_QRD0;
					end
				end
				S_SCMP: begin
					if (rd_pos < pos_q) begin
						lo_q <= mid_q + CW'(1);
					end else begin
						hi_q <= mid_q;
					end
					state_q <= S_SRCH;
				end
				S_LDCHK: begin
					if (rd_pos == pos_q) begin
						res_status_q <= ST_SKIPPED;
						state_q <= S_EMIT;
					end else if (count_q >= CW'(DEPTH)) begin
						res_status_q <= ST_FULL;
						state_q <= S_EMIT;
					end else begin
						k_q <= count_q;
						state_q <= S_SH;
					end
				end
				S_SH: begin
					if (k_q > lo_q) begin
						state_q <= S_SHWR;
					end else begin
						count_q <= count_q + CW'(1);
						res_status_q <= ST_LOADED;
						state_q <= S_EMIT;
					end
				end
				S_SHWR: begin
					k_q <= k_q - CW'(1);
					state_q <= S_SH;
				end
				S_QCHK: begin
					if (rd_pos == pos_q) begin
						res_value_q <= rd_val;
						res_status_q <= ST_EXACT;
						state_q <= S_EMIT;
					end else if (lo_q == '0) begin
						if (strict_q) begin
							res_status_q <= ST_RANGE;
							state_q <= S_EMIT;
						end else begin
							i0_q <= '0;
							res_status_q <= ST_EXTRAP;
							state_q <= S_QRD0;
						end
					end else begin
						i0_q <= AW'(lo_q - CW'(1));
						res_status_q <= ST_INTERP;
						state_q <= S_QRD0;
					end
				end
				S_QRD0: state_q <= S_QRD1;
				S_QRD1: begin
					p0_q <= rd_pos;
					v0_q <= $signed(rd_val);
					state_q <= S_QCAP;
				end
				S_QCAP: begin
					d_q <= (rd_pos > p0_q) ? rd_pos - p0_q : '0;
					a_q <= dq[PW] ? PW'(-dq) : PW'(dq);
					b_q <= dv[DVW-1] ? DVW'(-dv) : DVW'(dv);
					neg_q <= dq[PW] != dv[DVW-1];
					acc_q <= '0;
					cnt_q <= '0;
					if (rd_pos <= p0_q || dq == '0 || dv == '0) begin
						res_value_q <= v0_q;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					acc_q <= (acc_q << 1) + (a_q[PW-1] ? PRODW'(b_q) : '0);
					a_q <= a_q << 1;
					cnt_q <= cnt_q + STEPW'(1);
					if (cnt_q == STEPW'(PW - 1)) begin
						cnt_q <= '0;
						rem_q <= '0;
						quo_q <= '0;
						ovf_q <= 1'b0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= div_ge ? PW'(div_t - {1'b0, d_q}) : PW'(div_t);
					quo_q <= {quo_q[QW-2:0], div_ge};
					ovf_q <= ovf_q | quo_q[QW-1];
					acc_q <= acc_q << 1;
					cnt_q <= cnt_q + STEPW'(1);
					if (cnt_q == STEPW'(PRODW - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					res_value_q <= VW'(r_sat);
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_value_q <= res_value_q;
						out_status_q <= res_status_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`STLI_ASSERT_IMP(a_search_bounds, state_q == S_SRCH, lo_q <= hi_q && hi_q <= count_q, "search window out of bounds")
	`STLI_ASSERT_ALWAYS(a_count_max, count_q <= CW'(DEPTH), "entry count above table depth")
	`STLI_ASSERT_IMP(a_write_state, mem_we, state_q == S_SH || state_q == S_SHWR, "table write outside insert")
	`STLI_ASSERT_IMP(a_write_room, mem_we, count_q < CW'(DEPTH), "table write while full")
endmodule
